[hdl/fspa_pkg.sv]
// Shared types and codes for the fixed slot pool allocator.
// No dependencies; the controller, datapath and top level import this package.
package fspa_pkg;

	// request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // capture request, launch link read at head
		logic commit;  // update pool state, load output register
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_busy;  // output register holds a transaction that is not taken this cycle
	} dp_stat_t;

endpackage

[hdl/fspa_ctrl.sv]
// Controller state machine of the fixed slot pool allocator.
// Depends on fspa_pkg; drives the datapath through dp_cmd_t.
module fspa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  fspa_pkg::dp_stat_t stat,
	output fspa_pkg::dp_cmd_t  cmd
);
	import fspa_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;

	assign in_stall   = (state_q != S_IDLE);
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.commit = (state_q == S_EXEC) && !stat.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (!stat.out_busy) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/fspa_dp.sv]
// Datapath of the fixed slot pool allocator: link memory, head, count,
// set-up frontier and output register. Depends on fspa_pkg.
module fspa_dp #(
	parameter int SLOTS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fspa_pkg::dp_cmd_t  cmd,
	output fspa_pkg::dp_stat_t stat,
	input  logic              mode,
	input  logic [7:0]        slot_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        granted_slot,
	output logic [1:0]        status,
	output logic [8:0]        free_count
);
	import fspa_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [31:0] SLOTS_W = 32'(SLOTS);

	logic [CW-1:0] mem [SLOTS];

	logic          mode_q;
	logic [7:0]    slot_q;
	logic [CW-1:0] head_q;
	logic [CW-1:0] free_q;
	logic [CW-1:0] front_q;
	logic [CW-1:0] rd_q;
	logic          out_valid_q;
	logic [7:0]    granted_q;
	status_t       status_q;
	logic [8:0]    count_q;

	logic [31:0]   slot_w, head_w, front_w, free_w;
	logic [CW-1:0] front_inc, link_val;
	logic [CW-1:0] head_d, free_d, front_d;
	logic [31:0]   granted_w, count_w;
	status_t       status_d;
	logic          we;
	logic [AW-1:0] wa;
	logic [CW-1:0] wd;

	assign slot_w    = {24'd0, slot_q};
	assign head_w    = 32'(head_q);
	assign front_w   = 32'(front_q);
	assign free_w    = 32'(free_q);
	assign front_inc = CW'(front_q + 1'b1);

	// link of the head slot; forward the frontier link set up in this request
	always_comb begin
		if (head_w >= SLOTS_W) begin
			link_val = '0;
		end else if (front_w < SLOTS_W && head_q == front_q) begin
			link_val = front_inc;
		end else begin
			link_val = rd_q;
		end
	end

	always_comb begin
		head_d    = head_q;
		free_d    = free_q;
		front_d   = front_q;
		granted_w = 32'd0;
		status_d  = ST_OK;
		we        = 1'b0;
		wa        = front_q[AW-1:0];
		wd        = front_inc;
		if (mode_q == MODE_ALLOC) begin
			if (free_q == '0) begin
				status_d = ST_EMPTY;
			end else begin
				if (front_w < SLOTS_W) begin
					we      = 1'b1;
					front_d = front_inc;
				end
				granted_w = head_w;
				free_d    = CW'(free_q - 1'b1);
				head_d    = (free_w == 32'd1) ? '0 : link_val;
			end
		end else begin
			granted_w = slot_w;
			if (free_w >= SLOTS_W || slot_w >= SLOTS_W) begin
				status_d = ST_FULL;
			end else begin
				we     = 1'b1;
				wa     = slot_w[AW-1:0];
				wd     = head_q;
				head_d = slot_w[CW-1:0];
				free_d = CW'(free_q + 1'b1);
			end
		end
	end

	assign count_w = 32'(free_d);

	// link memory: one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.commit && we) mem[wa] <= wd;
		if (cmd.load) rd_q <= mem[head_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			slot_q <= slot_index;
		end
		if (cmd.commit) begin
			granted_q <= granted_w[7:0];
			status_q  <= status_d;
			count_q   <= count_w[8:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			free_q      <= CW'(SLOTS);
			front_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				head_q  <= head_d;
				free_q  <= free_d;
				front_q <= front_d;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_busy = out_valid_q && out_stall;
	assign out_valid     = out_valid_q;
	assign granted_slot  = granted_q;
	assign status        = status_q;
	assign free_count    = count_q;

endmodule

[hdl/fixed_slot_pool_allocator.sv]
// Fixed slot pool allocator with a lazily built free list.
// No new request is taken while one is in flight: the head slot's link comes from
// a registered read of the link memory, and a full, stalled output register holds
// back the commit of the request into the output register.
// Reset (arst_n low, asynchronous): pool full, head and set-up frontier at slot 0,
// no result pending. The link memory is not cleared; entries are written before use.
module fixed_slot_pool_allocator #(
	parameter int SLOTS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] slot_index,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] granted_slot,
	output logic [1:0] status,
	output logic [8:0] free_count
);
	import fspa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Controller: take a request transaction when idle, then commit it once the
	// output register can take the result. The datapath launches the link read
	// at the head slot on the accept edge, so the commit cycle sees its data.
	fspa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: on commit, an allocate sets up the frontier link (if any are left),
	// pops the head and follows its link; a free pushes the slot on the head.
	// The result transaction waits in the output register while the next request
	// is accepted.
	fspa_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.slot_index   (slot_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted_slot (granted_slot),
		.status       (status),
		.free_count   (free_count)
	);

endmodule
